### rtl/nipd_pkg.sv
// Shared types, constants and the interval match function of the NEC IR decoder.
// Used by the channel interfaces and by every decoder module; depends on nothing.
package nipd_pkg;

  // Widths of the interval, the command byte and the error tally.
  localparam int TIME_W   = 16;
  localparam int CMD_W    = 8;
  localparam int TALLY_W  = 16;
  localparam int FRAME_W  = 32;
  localparam int BITCNT_W = 6;
  localparam int CFG_IDX_W = 3;
  // 5 * 65535 and 6 * 65535 both fit in 19 bits.
  localparam int SCALED_W = TIME_W + 3;

  localparam logic [BITCNT_W-1:0] FRAME_LEN = BITCNT_W'(FRAME_W);
  localparam logic [TALLY_W-1:0]  TALLY_MAX = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEAD_BURST   = 3'd0,
    CFG_LEAD_SPACE   = 3'd1,
    CFG_BIT_BURST    = 3'd2,
    CFG_ZERO_SPACE   = 3'd3,
    CFG_ONE_SPACE    = 3'd4,
    CFG_REPEAT_SPACE = 3'd5,
    CFG_REPEAT_END   = 3'd6
  } cfg_reg_t;

  // Reset values of the nominal times in microseconds.
  localparam logic [TIME_W-1:0] RST_LEAD_BURST   = 16'd9000;
  localparam logic [TIME_W-1:0] RST_LEAD_SPACE   = 16'd4500;
  localparam logic [TIME_W-1:0] RST_BIT_BURST    = 16'd562;
  localparam logic [TIME_W-1:0] RST_ZERO_SPACE   = 16'd562;
  localparam logic [TIME_W-1:0] RST_ONE_SPACE    = 16'd1688;
  localparam logic [TIME_W-1:0] RST_REPEAT_SPACE = 16'd2250;
  localparam logic [TIME_W-1:0] RST_REPEAT_END   = 16'd562;

  // Classified interval: one match flag per nominal time.
  typedef struct packed {
    logic lead_burst;
    logic lead_space;
    logic bit_burst;
    logic zero_space;
    logic one_space;
    logic repeat_space;
    logic repeat_end;
  } match_t;

  // Write request from the front part into the queue.
  typedef struct packed {
    logic   valid;
    match_t classes;
  } push_t;

  // The interval lies strictly within 0.8 and 1.2 times nominal: 5x > 4y and 5x < 6y.
  function automatic logic near_nominal(logic [TIME_W-1:0] x, logic [TIME_W-1:0] y);
    logic [SCALED_W-1:0] x5;
    logic [SCALED_W-1:0] y4;
    logic [SCALED_W-1:0] y6;
    x5 = {1'b0, x, 2'b00} + {3'b000, x};
    y4 = {1'b0, y, 2'b00};
    y6 = {1'b0, y, 2'b00} + {2'b00, y, 1'b0};
    return (x5 > y4) && (x5 < y6);
  endfunction

endpackage

### rtl/nipd_ifs.sv
// Valid/ready channel interfaces for edge intervals and decoder results.
// Depends on nipd_pkg for the field widths.
interface nipd_interval_if;
  logic                        valid;
  logic                        ready;
  logic [nipd_pkg::TIME_W-1:0] interval_us;

  modport source (output valid, output interval_us, input ready);
  modport sink   (input valid, input interval_us, output ready);
endinterface

interface nipd_result_if;
  logic                         valid;
  logic                         ready;
  logic                         frame_received;
  logic [nipd_pkg::CMD_W-1:0]   command;
  logic                         error_pulse;
  logic [nipd_pkg::TALLY_W-1:0] error_total;

  modport source (output valid, output frame_received, output command,
                  output error_pulse, output error_total, input ready);
  modport sink   (input valid, input frame_received, input command,
                  input error_pulse, input error_total, output ready);
endinterface

### rtl/nipd_front.sv
// Front part: holds the nominal time registers and classifies each accepted interval.
// Depends on nipd_pkg and nipd_interval_if.
module nipd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nipd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nipd_pkg::TIME_W-1:0]    cfg_data,
  nipd_interval_if.sink                  intervals,
  input  logic                           q_ready,
  output nipd_pkg::push_t                push
);

  logic [nipd_pkg::TIME_W-1:0] lead_burst_time;
  logic [nipd_pkg::TIME_W-1:0] lead_space_time;
  logic [nipd_pkg::TIME_W-1:0] bit_burst_time;
  logic [nipd_pkg::TIME_W-1:0] zero_space_time;
  logic [nipd_pkg::TIME_W-1:0] one_space_time;
  logic [nipd_pkg::TIME_W-1:0] repeat_space_time;
  logic [nipd_pkg::TIME_W-1:0] repeat_end_time;

  // Configuration register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_burst_time   <= nipd_pkg::RST_LEAD_BURST;
      lead_space_time   <= nipd_pkg::RST_LEAD_SPACE;
      bit_burst_time    <= nipd_pkg::RST_BIT_BURST;
      zero_space_time   <= nipd_pkg::RST_ZERO_SPACE;
      one_space_time    <= nipd_pkg::RST_ONE_SPACE;
      repeat_space_time <= nipd_pkg::RST_REPEAT_SPACE;
      repeat_end_time   <= nipd_pkg::RST_REPEAT_END;
    end else if (cfg_we) begin
      case (cfg_index)
        nipd_pkg::CFG_LEAD_BURST:   lead_burst_time   <= cfg_data;
        nipd_pkg::CFG_LEAD_SPACE:   lead_space_time   <= cfg_data;
        nipd_pkg::CFG_BIT_BURST:    bit_burst_time    <= cfg_data;
        nipd_pkg::CFG_ZERO_SPACE:   zero_space_time   <= cfg_data;
        nipd_pkg::CFG_ONE_SPACE:    one_space_time    <= cfg_data;
        nipd_pkg::CFG_REPEAT_SPACE: repeat_space_time <= cfg_data;
        nipd_pkg::CFG_REPEAT_END:   repeat_end_time   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept whenever the queue has room.
  assign intervals.ready = q_ready;

  // Compare the interval against every nominal time at once.
  always_comb begin
    push.valid = intervals.valid && q_ready;
    push.classes.lead_burst   = nipd_pkg::near_nominal(intervals.interval_us, lead_burst_time);
    push.classes.lead_space   = nipd_pkg::near_nominal(intervals.interval_us, lead_space_time);
    push.classes.bit_burst    = nipd_pkg::near_nominal(intervals.interval_us, bit_burst_time);
    push.classes.zero_space   = nipd_pkg::near_nominal(intervals.interval_us, zero_space_time);
    push.classes.one_space    = nipd_pkg::near_nominal(intervals.interval_us, one_space_time);
    push.classes.repeat_space =
      nipd_pkg::near_nominal(intervals.interval_us, repeat_space_time);
    push.classes.repeat_end   = nipd_pkg::near_nominal(intervals.interval_us, repeat_end_time);
  end

endmodule

### rtl/nipd_queue.sv
// Two-entry queue of classified intervals between the front and back parts.
// Depends on nipd_pkg for the entry type.
module nipd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  nipd_pkg::push_t      push,
  output logic                 q_ready,
  output logic                 q_valid,
  output nipd_pkg::match_t     q_data,
  input  logic                 pop
);

  nipd_pkg::match_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign q_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data  = entries[rd_ptr];
  assign do_pop  = pop && q_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push.valid} - {1'b0, do_pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.classes;
    end
  end

endmodule

### rtl/nipd_back.sv
// Back part: the NEC phase machine, frame assembly, error tally and result register.
// Depends on nipd_pkg and nipd_result_if.
module nipd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  nipd_pkg::match_t q_data,
  output logic             pop,
  nipd_result_if.source    results
);

  typedef enum logic [2:0] {
    PH_LEAD_BURST = 3'd0,
    PH_LEAD_SPACE = 3'd1,
    PH_REPEAT_END = 3'd2,
    PH_BIT_BURST  = 3'd3,
    PH_BIT_SPACE  = 3'd4
  } phase_t;

  phase_t                             phase;
  phase_t                             phase_next;
  logic [nipd_pkg::FRAME_W-1:0]       frame_bits;
  logic [nipd_pkg::FRAME_W-1:0]       frame_bits_next;
  logic [nipd_pkg::BITCNT_W-1:0]      bit_count;
  logic [nipd_pkg::BITCNT_W-1:0]      bit_count_next;
  logic [nipd_pkg::CMD_W-1:0]         last_command;
  logic [nipd_pkg::CMD_W-1:0]         last_command_next;
  logic [nipd_pkg::TALLY_W-1:0]       error_tally;
  logic [nipd_pkg::TALLY_W-1:0]       error_tally_next;
  logic                               got;
  logic                               err;
  logic                               res_valid;
  logic                               res_frame;
  logic                               res_error;

  // Take the next entry when the result register is empty or being drained.
  assign pop = q_valid && (!res_valid || results.ready);

  assign results.valid          = res_valid;
  assign results.frame_received = res_frame;
  assign results.command        = last_command;
  assign results.error_pulse    = res_error;
  assign results.error_total    = error_tally;

  // Next state of the decoder for the entry at the head of the queue.
  always_comb begin
    phase_next        = phase;
    frame_bits_next   = frame_bits;
    bit_count_next    = bit_count;
    last_command_next = last_command;
    got               = 1'b0;
    err               = 1'b0;
    unique case (phase)
      PH_LEAD_BURST: begin
        if (q_data.lead_burst) begin
          phase_next      = PH_LEAD_SPACE;
          frame_bits_next = '0;
          bit_count_next  = '0;
        end
      end
      PH_LEAD_SPACE: begin
        if (q_data.lead_space) begin
          phase_next = PH_BIT_BURST;
        end else if (q_data.repeat_space) begin
          phase_next = PH_REPEAT_END;
        end else begin
          err        = 1'b1;
          phase_next = PH_LEAD_BURST;
        end
      end
      PH_REPEAT_END: begin
        // A matching closing burst leaves the decoder where it is.
        if (!q_data.repeat_end) begin
          err        = 1'b1;
          phase_next = PH_LEAD_BURST;
        end
      end
      PH_BIT_BURST: begin
        if (q_data.bit_burst) begin
          phase_next = PH_BIT_SPACE;
        end else begin
          err        = 1'b1;
          phase_next = PH_LEAD_BURST;
        end
      end
      PH_BIT_SPACE: begin
        phase_next = PH_BIT_BURST;
        if (q_data.zero_space) begin
          bit_count_next = bit_count + 1'b1;
        end else if (q_data.one_space) begin
          frame_bits_next[bit_count[4:0]] = 1'b1;
          bit_count_next = bit_count + 1'b1;
        end else begin
          err        = 1'b1;
          phase_next = PH_LEAD_BURST;
        end
        // Full frame: address and command must each match their inverse byte.
        if (bit_count_next == nipd_pkg::FRAME_LEN) begin
          if ((frame_bits_next[7:0] == ~frame_bits_next[15:8]) &&
              (frame_bits_next[23:16] == ~frame_bits_next[31:24])) begin
            last_command_next = frame_bits_next[23:16];
            got               = 1'b1;
          end else begin
            err = 1'b1;
          end
          phase_next = PH_LEAD_BURST;
        end
      end
      default: begin
        phase_next = PH_LEAD_BURST;
      end
    endcase
    // Saturating error count.
    error_tally_next = error_tally;
    if (err && (error_tally != nipd_pkg::TALLY_MAX)) begin
      error_tally_next = error_tally + 1'b1;
    end
  end

  // Decoder state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEAD_BURST;
      frame_bits   <= '0;
      bit_count    <= '0;
      last_command <= '0;
      error_tally  <= '0;
      res_valid    <= 1'b0;
      res_frame    <= 1'b0;
      res_error    <= 1'b0;
    end else begin
      if (pop) begin
        phase        <= phase_next;
        frame_bits   <= frame_bits_next;
        bit_count    <= bit_count_next;
        last_command <= last_command_next;
        error_tally  <= error_tally_next;
        res_valid    <= 1'b1;
        res_frame    <= got;
        res_error    <= err;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/nec_ir_pulse_decoder.sv
// NEC infrared frame decoder fed with the time between receiver edges, one
// result for every interval. It takes one interval per clock cycle while the
// queue has room. The front part classifies the interval against all seven
// nominal times in the transfer cycle, a two-entry queue holds the classes,
// and the back part's phase machine updates the frame, command and error
// tally once per entry and loads the result register, so either side may
// stall until the queue is full without blocking the other. Nominal times
// are written through cfg_we/cfg_index/cfg_data while no interval is in
// flight; the user must keep to this, as the block does not enforce it.
// Depends on nipd_pkg, the channel interfaces, nipd_front, nipd_queue and nipd_back.
module nec_ir_pulse_decoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nipd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nipd_pkg::TIME_W-1:0]    cfg_data,
  nipd_interval_if.sink                  intervals,
  nipd_result_if.source                  results
);

  nipd_pkg::push_t  push;
  nipd_pkg::match_t q_data;
  logic             q_ready;
  logic             q_valid;
  logic             pop;

  // Classification of incoming intervals.
  nipd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .intervals (intervals),
    .q_ready   (q_ready),
    .push      (push)
  );

  // Decoupling queue.
  nipd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .q_ready (q_ready),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop)
  );

  // Frame decoding and results.
  nipd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .results (results)
  );

endmodule

### tb/nipd_decode_checker.sv
// Scoreboard for the NEC IR pulse decoder: mirrors the timing registers, decodes
// each transferred interval itself and compares every result transfer in order.
// Depends on nipd_pkg and the channel interfaces in nipd_ifs.
module nipd_decode_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nipd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nipd_pkg::TIME_W-1:0]    cfg_data,
  nipd_interval_if                       intervals,
  nipd_result_if                         results,
  output int                             mismatches,
  output int                             awaiting,
  output int                             frames_predicted,
  output int                             errors_predicted
);
  import nipd_pkg::*;

  typedef enum logic [2:0] {
    WAIT_LEAD_BURST = 3'd0,
    WAIT_LEAD_SPACE = 3'd1,
    IN_REPEAT_END   = 3'd2,
    WAIT_BIT_BURST  = 3'd3,
    WAIT_BIT_SPACE  = 3'd4
  } decode_phase_t;

  typedef struct packed {
    logic               frame_received;
    logic [CMD_W-1:0]   command;
    logic               error_pulse;
    logic [TALLY_W-1:0] error_total;
  } decode_result_t;

  // Mirrored nominal times and the decoder state as this model sees it.
  logic [TIME_W-1:0]   nominal [7];
  decode_phase_t       phase_q;
  logic [FRAME_W-1:0]  frame_q;
  logic [BITCNT_W-1:0] nbits_q;
  logic [CMD_W-1:0]    command_q;
  logic [TALLY_W-1:0]  tally_q;
  decode_result_t      expected_q [$];

  // True when x lies strictly between 0.8 and 1.2 times y, done in integers.
  function automatic logic within_tolerance(logic [TIME_W-1:0] x, logic [TIME_W-1:0] y);
    int unsigned x5;
    int unsigned y4;
    int unsigned y6;
    x5 = 5 * int'(x);
    y4 = 4 * int'(y);
    y6 = 6 * int'(y);
    return (x5 > y4) && (x5 < y6);
  endfunction

  // The tally sticks at its maximum once it gets there.
  function automatic void bump_tally();
    if (tally_q != TALLY_MAX) begin
      tally_q = tally_q + 1'b1;
    end
  endfunction

  // Advances the model by one interval and returns the result it should produce.
  function automatic decode_result_t decode_edge(logic [TIME_W-1:0] t);
    decode_result_t r;
    r = '0;
    case (phase_q)
      WAIT_LEAD_BURST: begin
        if (within_tolerance(t, nominal[CFG_LEAD_BURST])) begin
          phase_q = WAIT_LEAD_SPACE;
          frame_q = '0;
          nbits_q = '0;
        end
      end
      WAIT_LEAD_SPACE: begin
        if (within_tolerance(t, nominal[CFG_LEAD_SPACE])) begin
          phase_q = WAIT_BIT_BURST;
        end else if (within_tolerance(t, nominal[CFG_REPEAT_SPACE])) begin
          phase_q = IN_REPEAT_END;
        end else begin
          bump_tally();
          r.error_pulse = 1'b1;
          phase_q = WAIT_LEAD_BURST;
        end
      end
      IN_REPEAT_END: begin
        // A matching closing burst keeps the decoder here.
        if (!within_tolerance(t, nominal[CFG_REPEAT_END])) begin
          bump_tally();
          r.error_pulse = 1'b1;
          phase_q = WAIT_LEAD_BURST;
        end
      end
      WAIT_BIT_BURST: begin
        if (within_tolerance(t, nominal[CFG_BIT_BURST])) begin
          phase_q = WAIT_BIT_SPACE;
        end else begin
          bump_tally();
          r.error_pulse = 1'b1;
          phase_q = WAIT_LEAD_BURST;
        end
      end
      WAIT_BIT_SPACE: begin
        phase_q = WAIT_BIT_BURST;
        if (within_tolerance(t, nominal[CFG_ZERO_SPACE])) begin
          nbits_q = nbits_q + 1'b1;
        end else if (within_tolerance(t, nominal[CFG_ONE_SPACE])) begin
          frame_q[nbits_q[4:0]] = 1'b1;
          nbits_q = nbits_q + 1'b1;
        end else begin
          bump_tally();
          r.error_pulse = 1'b1;
          phase_q = WAIT_LEAD_BURST;
        end
        // A full frame is checked against its inverted address and command bytes.
        if (nbits_q == FRAME_LEN) begin
          if (frame_q[7:0] == ~frame_q[15:8] && frame_q[23:16] == ~frame_q[31:24]) begin
            command_q = frame_q[23:16];
            r.frame_received = 1'b1;
          end else begin
            bump_tally();
            r.error_pulse = 1'b1;
          end
          phase_q = WAIT_LEAD_BURST;
        end
      end
      default: begin
        phase_q = WAIT_LEAD_BURST;
      end
    endcase
    r.command     = command_q;
    r.error_total = tally_q;
    return r;
  endfunction

  // Register mirror, prediction on interval transfers, comparison on result transfers.
  always @(posedge clk) begin
    decode_result_t want;
    int bad;
    bad = 0;
    if (rst) begin
      nominal[CFG_LEAD_BURST]   = RST_LEAD_BURST;
      nominal[CFG_LEAD_SPACE]   = RST_LEAD_SPACE;
      nominal[CFG_BIT_BURST]    = RST_BIT_BURST;
      nominal[CFG_ZERO_SPACE]   = RST_ZERO_SPACE;
      nominal[CFG_ONE_SPACE]    = RST_ONE_SPACE;
      nominal[CFG_REPEAT_SPACE] = RST_REPEAT_SPACE;
      nominal[CFG_REPEAT_END]   = RST_REPEAT_END;
      phase_q   = WAIT_LEAD_BURST;
      frame_q   = '0;
      nbits_q   = '0;
      command_q = '0;
      tally_q   = '0;
      expected_q.delete();
      mismatches       <= 0;
      awaiting         <= 0;
      frames_predicted <= 0;
      errors_predicted <= 0;
    end else begin
      if (cfg_we && cfg_index <= CFG_REPEAT_END) begin
        nominal[cfg_index] = cfg_data;
      end

      if (results.valid && results.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no decoded interval waiting for it");
          bad++;
        end else begin
          want = expected_q.pop_front();
          if (results.frame_received !== want.frame_received) begin
            $error("frame_received: expected %0d, got %0d",
                   want.frame_received, results.frame_received);
            bad++;
          end
          if (results.command !== want.command) begin
            $error("command: expected 0x%02h, got 0x%02h", want.command, results.command);
            bad++;
          end
          if (results.error_pulse !== want.error_pulse) begin
            $error("error_pulse: expected %0d, got %0d", want.error_pulse, results.error_pulse);
            bad++;
          end
          if (results.error_total !== want.error_total) begin
            $error("error_total: expected %0d, got %0d", want.error_total, results.error_total);
            bad++;
          end
        end
      end

      if (intervals.valid && intervals.ready) begin
        want = decode_edge(intervals.interval_us);
        expected_q.push_back(want);
        if (want.frame_received) begin
          frames_predicted <= frames_predicted + 1;
        end
        if (want.error_pulse) begin
          errors_predicted <= errors_predicted + 1;
        end
      end

      awaiting   <= expected_q.size();
      mismatches <= mismatches + bad;
    end
  end

endmodule

### tb/nec_ir_pulse_decoder_tb.sv
// Top of the NEC IR pulse decoder testbench: clock, reset, timing writes and
// interval stimulus, plus the verdict. Depends on nipd_pkg, nipd_ifs, the decoder
// and nipd_decode_checker.
module nec_ir_pulse_decoder_tb;
  import nipd_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIME_W-1:0]    cfg_data;

  nipd_interval_if interval_ch ();
  nipd_result_if   result_ch ();

  int mismatches;
  int awaiting;
  int frames_predicted;
  int errors_predicted;

  // Stimulus side copy of the timings, used to aim intervals at each nominal time.
  logic [TIME_W-1:0] timing [7];
  int src_idle_pct  = 38;
  int sink_idle_pct = 85;
  int items_sent    = 0;
  int settings_done = 0;
  int quiet_cycles  = 0;

  nec_ir_pulse_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .intervals (interval_ch),
    .results   (result_ch)
  );

  nipd_decode_checker scoreboard (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .intervals        (interval_ch),
    .results          (result_ch),
    .mismatches       (mismatches),
    .awaiting         (awaiting),
    .frames_predicted (frames_predicted),
    .errors_predicted (errors_predicted)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // The result side stalls at random at the current idle rate.
  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Ends the run if nothing is transferred for too long.
  always @(posedge clk) begin
    if (rst || cfg_we || (interval_ch.valid && interval_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one interval, with random idle cycles first, and waits for its transfer.
  task automatic push_interval(input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < src_idle_pct) begin
      interval_ch.valid <= 1'b0;
      @(posedge clk);
    end
    interval_ch.valid       <= 1'b1;
    interval_ch.interval_us <= t;
    @(posedge clk);
    while (!interval_ch.ready) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Stops sending until every predicted result has come out, then lets the pipe settle.
  task automatic drain();
    interval_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (awaiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [TIME_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    timing[idx] = v;
    @(posedge clk);
  endtask

  // Loads a full set of nominal times while the decoder is idle.
  task automatic set_timings(input int lb, input int ls, input int bb, input int zs,
                             input int os, input int rs, input int re);
    drain();
    write_reg(CFG_LEAD_BURST, TIME_W'(lb));
    write_reg(CFG_LEAD_SPACE, TIME_W'(ls));
    write_reg(CFG_BIT_BURST, TIME_W'(bb));
    write_reg(CFG_ZERO_SPACE, TIME_W'(zs));
    write_reg(CFG_ONE_SPACE, TIME_W'(os));
    write_reg(CFG_REPEAT_SPACE, TIME_W'(rs));
    write_reg(CFG_REPEAT_END, TIME_W'(re));
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  // Picks an interval that matches nominal y, often right at the tolerance edge,
  // or one that just misses it or is arbitrary.
  function automatic logic [TIME_W-1:0] pick_interval(input logic [TIME_W-1:0] y,
                                                      input bit hit);
    int lo;
    int hi;
    lo = (4 * int'(y)) / 5 + 1;
    hi = (6 * int'(y) - 1) / 5;
    if (hi > 65535) begin
      hi = 65535;
    end
    if (hit && lo <= hi) begin
      case ($urandom_range(9))
        0:       return TIME_W'(lo);
        1:       return TIME_W'(hi);
        default: return TIME_W'($urandom_range(hi, lo));
      endcase
    end
    case ($urandom_range(2))
      0:       return TIME_W'(lo - 1);
      1:       return (hi < 65535) ? TIME_W'(hi + 1) : '0;
      default: return TIME_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_slot(input logic [TIME_W-1:0] y, inout int slot, input int cut);
    push_interval(pick_interval(y, slot != cut));
    slot++;
  endtask

  // Sends a whole frame LSB first; the slot numbered cut gets an interval that misses or is arbitrary.
  task automatic send_frame(input logic [FRAME_W-1:0] bits, input int cut);
    int slot;
    slot = 0;
    send_slot(timing[CFG_LEAD_BURST], slot, cut);
    send_slot(timing[CFG_LEAD_SPACE], slot, cut);
    for (int i = 0; i < FRAME_W; i++) begin
      send_slot(timing[CFG_BIT_BURST], slot, cut);
      send_slot(bits[i] ? timing[CFG_ONE_SPACE] : timing[CFG_ZERO_SPACE], slot, cut);
    end
  endtask

  // One random sequence: mostly frames, some repeat codes, broken frames and noise.
  task automatic emit_sequence();
    int pick;
    logic [CMD_W-1:0] addr;
    logic [CMD_W-1:0] cmd;
    pick = $urandom_range(99);
    addr = CMD_W'($urandom);
    cmd  = CMD_W'($urandom);
    if (pick < 35) begin
      send_frame({~cmd, cmd, ~addr, addr}, -1);
    end else if (pick < 45) begin
      send_frame(FRAME_W'($urandom), -1);
    end else if (pick < 60) begin
      send_frame({~cmd, cmd, ~addr, addr}, $urandom_range(2 * FRAME_W + 1));
    end else if (pick < 80) begin
      push_interval(pick_interval(timing[CFG_LEAD_BURST], 1'b1));
      push_interval(pick_interval(timing[CFG_REPEAT_SPACE], 1'b1));
      repeat ($urandom_range(3, 1)) push_interval(pick_interval(timing[CFG_REPEAT_END], 1'b1));
      if ($urandom_range(1) == 0) begin
        push_interval(pick_interval(timing[CFG_REPEAT_END], 1'b0));
      end
    end else begin
      repeat ($urandom_range(6, 1)) push_interval(TIME_W'($urandom_range(65535)));
    end
  endtask

  task automatic run_random(input int budget);
    int start;
    start = items_sent;
    while (items_sent - start < budget) begin
      // Now and then hold off until the decoder has emptied.
      if ($urandom_range(149) == 0) begin
        drain();
      end
      emit_sequence();
    end
  endtask

  initial begin
    // Reset timings: ignored leader noise, a bad leader space, a bad bit burst, a
    // repeat code held and then broken, and a bad bit space after one bit.
    int directed_iv [20] = '{0, 65535, 9000, 0, 7201, 4500, 65535, 10799, 2250, 562,
                             450, 65535, 9000, 5399, 562, 1688, 562, 3000, 7200, 10800};
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_index               <= CFG_LEAD_BURST;
    cfg_data                <= '0;
    interval_ch.valid       <= 1'b0;
    interval_ch.interval_us <= '0;
    timing[CFG_LEAD_BURST]   = RST_LEAD_BURST;
    timing[CFG_LEAD_SPACE]   = RST_LEAD_SPACE;
    timing[CFG_BIT_BURST]    = RST_BIT_BURST;
    timing[CFG_ZERO_SPACE]   = RST_ZERO_SPACE;
    timing[CFG_ONE_SPACE]    = RST_ONE_SPACE;
    timing[CFG_REPEAT_SPACE] = RST_REPEAT_SPACE;
    timing[CFG_REPEAT_END]   = RST_REPEAT_END;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct  = 38;
    sink_idle_pct = 85;
    foreach (directed_iv[i]) begin
      push_interval(TIME_W'(directed_iv[i]));
    end
    set_timings(9000, 4500, 560, 560, 1690, 2250, 560);
    run_random(250);

    src_idle_pct  = 85;
    sink_idle_pct = 38;
    set_timings($urandom_range(65535, 1), $urandom_range(65535, 1), $urandom_range(65535, 1),
                $urandom_range(65535, 1), $urandom_range(65535, 1), $urandom_range(65535, 1),
                $urandom_range(65535, 1));
    run_random(250);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_timings(1, 1, 1, 1, 1, 1, 1);
    run_random(60);
    set_timings(65535, 65535, 65535, 65535, 65535, 65535, 65535);
    run_random(60);
    // Zero nominal times can never be matched.
    set_timings(9000, 4500, 562, 0, 1688, 0, 0);
    run_random(60);
    set_timings(10, 20, 30, 40, 50, 60, 70);
    run_random(60);

    // A good frame followed by one whose address check fails.
    send_frame({8'h5a, 8'ha5, 8'hc3, 8'h3c}, -1);
    send_frame({8'h5a, 8'ha5, 8'hc3, 8'h3d}, -1);
    drain();

    $display("Checked %0d intervals under %0d timing settings with three idle mixes.",
             items_sent, settings_done + 1);
    $display("Predicted %0d good frames and %0d error events, edge and zero timings included.",
             frames_predicted, errors_predicted);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/nipd_pkg.sv
rtl/nipd_ifs.sv
rtl/nipd_front.sv
rtl/nipd_queue.sv
rtl/nipd_back.sv
rtl/nec_ir_pulse_decoder.sv
tb/nipd_decode_checker.sv
tb/nec_ir_pulse_decoder_tb.sv
